@@ rtl/core/irct_pkg.sv @@
`default_nettype none
package irct_pkg;

    localparam int OFFSET_BITS = 48;
    localparam int LENGTH_BITS = 32;
    localparam int END_BITS    = 49;

    typedef enum logic [1:0] {
        ACT_SUBMIT   = 2'd0,
        ACT_COMPLETE = 2'd1,
        ACT_CLEAR    = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_WAIT_FULL = 2'd2,
        ST_ERASE_MISS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SCAN,
        PH_HEAD_RD,
        PH_HEAD_SCAN,
        PH_DONE
    } phase_t;

    // Command travelling down the cell chain
    typedef struct packed {
        logic                   check;   // overlap check of lo/hi
        logic                   erase;   // erase first entry with start == lo
        logic                   clear;   // drop every entry
        logic [OFFSET_BITS-1:0] lo;
        logic [END_BITS-1:0]    hi;
    } cell_cmd_t;

    // Summary travelling down the chain, gathered by each cell
    typedef struct packed {
        logic conflict;
        logic free_seen;
        logic hit;
    } cell_sum_t;

endpackage
`default_nettype wire

@@ rtl/core/irct_ram.sv @@
`default_nettype none
module irct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/irct_cell.sv @@
`default_nettype none
module irct_cell
    import irct_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire cell_sum_t sum_in,
    input  wire logic      alloc,      // claim this cell if it is the first free one
    output cell_sum_t      sum_out
);
    logic                   valid_reg;
    logic                   valid_next;
    logic [OFFSET_BITS-1:0] start_reg;
    logic [END_BITS-1:0]    end_reg;
    logic                   overlap;
    logic                   match;
    logic                   take;

    assign overlap = valid_reg && ({1'b0, start_reg} < cmd.hi) && (end_reg > {1'b0, cmd.lo});
    assign match   = valid_reg && (start_reg == cmd.lo) && !sum_in.hit;
    assign take    = alloc && !valid_reg && !sum_in.free_seen;

    // Fold this cell into the running summary
    always_comb
    begin
        sum_out.conflict  = sum_in.conflict || (cmd.check && overlap);
        sum_out.free_seen = sum_in.free_seen || !valid_reg;
        sum_out.hit       = sum_in.hit || (cmd.erase && match);
    end

    // Update the valid bit
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.erase && match)
        begin
            valid_next = 1'b0;
        end
        else if (take)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the range of a claimed entry
    always_ff @(posedge clk)
    begin
        if (take && !cmd.clear)
        begin
            start_reg <= cmd.lo;
            end_reg   <= cmd.hi;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/irct_chain.sv @@
`default_nettype none
module irct_chain
    import irct_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire logic      alloc,
    output cell_sum_t      sum
);
    cell_sum_t sum_w [TABLE_ENTRIES+1];

    assign sum_w[0] = '{conflict: 1'b0, free_seen: 1'b0, hit: 1'b0};
    assign sum      = sum_w[TABLE_ENTRIES];

    // Row of table cells, summary rippling from cell to cell
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        irct_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .sum_in  (sum_w[i]),
            .alloc   (alloc),
            .sum_out (sum_w[i+1])
        );
    end
endmodule
`default_nettype wire

@@ rtl/core/inflight_range_conflict_tracker_core.sv @@
// Phases: an accepted item goes through a table scan and a done phase before its result
// is registered; a completion with a non-empty pending FIFO re-checks the pending head
// (table scan, pending-head read from RAM, then a second scan) before the done phase.
// Throughput: one item at a time; the next item is not accepted until the result is
// taken, since s_tready waits for the idle phase with no result held.
// Reset (rst_n low, asynchronous) empties the table, the pending FIFO and counts.
`default_nettype none
module inflight_range_conflict_tracker_core
    import irct_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int WAIT_DEPTH    = 32,
    parameter int TAG_BITS      = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // action[1:0], offset[49:2], length[81:50], request_tag[97:82],
    // queue_if_blocked[98], zero fill to 104
    input  wire logic [103:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // accepted[0], issued_valid[1], issued_tag[17:2], status[19:18],
    // inflight_count[26:20], pending_count[32:27], zero fill to 40
    output logic [39:0]       m_tdata
);
    localparam int CNT_BITS  = $clog2(TABLE_ENTRIES + 1);
    localparam int FILL_BITS = $clog2(WAIT_DEPTH + 1);
    localparam int PTR_BITS  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WAIT_W    = TAG_BITS + OFFSET_BITS + LENGTH_BITS;

    phase_t  phase_reg, phase_next;
    logic [1:0]             act_reg;
    logic [OFFSET_BITS-1:0] lo_reg;
    logic [LENGTH_BITS-1:0] len_reg;
    logic [TAG_BITS-1:0]    tag_reg;
    logic                   queue_reg;
    logic                   acc_reg;
    logic [1:0]             status_reg;
    logic                   iss_reg;
    logic [TAG_BITS-1:0]    itag_reg;
    logic [CNT_BITS-1:0]    busy_reg;
    logic [FILL_BITS-1:0]   fill_reg;
    logic [PTR_BITS-1:0]    head_reg;
    logic                   out_valid_reg;

    cell_cmd_t cmd;
    cell_sum_t sum;
    logic      alloc;
    logic      s_acc;
    logic      wr_en;
    logic [PTR_BITS-1:0] wr_ptr;
    logic [WAIT_W-1:0]   head_data;
    logic [TAG_BITS-1:0]    h_tag;
    logic [OFFSET_BITS-1:0] h_lo;
    logic [LENGTH_BITS-1:0] h_len;
    logic [PTR_BITS:0]      ptr_sum;

    assign s_tready = (phase_reg == PH_IDLE) && !out_valid_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign {h_tag, h_len, h_lo} = head_data;

    // Pending FIFO storage
    assign ptr_sum = {1'b0, head_reg} + (PTR_BITS+1)'(fill_reg);
    always_comb
    begin
        if (ptr_sum >= (PTR_BITS+1)'(WAIT_DEPTH))
        begin
            wr_ptr = PTR_BITS'(ptr_sum - (PTR_BITS+1)'(WAIT_DEPTH));
        end
        else
        begin
            wr_ptr = ptr_sum[PTR_BITS-1:0];
        end
    end

    irct_ram #(.WIDTH(WAIT_W), .DEPTH(WAIT_DEPTH)) u_wait (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_ptr),
        .wdata ({tag_reg, len_reg, lo_reg}),
        .raddr (head_reg),
        .rdata (head_data)
    );

    irct_chain #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .alloc (alloc),
        .sum   (sum)
    );

    // Drive the chain command for the current phase
    always_comb
    begin
        cmd   = '{check: 1'b0, erase: 1'b0, clear: 1'b0, lo: lo_reg,
                  hi: {1'b0, lo_reg} + END_BITS'(len_reg)};
        alloc = 1'b0;
        wr_en = 1'b0;
        case (phase_reg)
            PH_SCAN:
            begin
                if (act_reg == ACT_SUBMIT && len_reg != '0)
                begin
                    cmd.check = 1'b1;
                    alloc     = !sum.conflict;
                    wr_en     = (sum.conflict || !sum.free_seen) && queue_reg &&
                                (fill_reg < FILL_BITS'(WAIT_DEPTH));
                end
                else if (act_reg == ACT_COMPLETE && len_reg != '0)
                begin
                    cmd.erase = 1'b1;
                end
                else if (act_reg == ACT_CLEAR)
                begin
                    cmd.clear = 1'b1;
                end
            end
            PH_HEAD_SCAN:
            begin
                cmd.lo    = h_lo;
                cmd.hi    = {1'b0, h_lo} + END_BITS'(h_len);
                cmd.check = (h_len != '0);
                alloc     = (h_len != '0) && !sum.conflict;
            end
            default:
            begin
            end
        endcase
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:      if (s_acc) phase_next = PH_SCAN;
            PH_SCAN:      phase_next = (act_reg == ACT_COMPLETE && fill_reg != '0) ?
                                       PH_HEAD_RD : PH_DONE;
            PH_HEAD_RD:   phase_next = PH_HEAD_SCAN;
            PH_HEAD_SCAN: phase_next = PH_DONE;
            PH_DONE:      phase_next = PH_IDLE;
            default:      phase_next = PH_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            busy_reg      <= '0;
            fill_reg      <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (phase_reg == PH_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            if (phase_reg == PH_SCAN)
            begin
                if (act_reg == ACT_CLEAR)
                begin
                    busy_reg <= '0;
                    fill_reg <= '0;
                    head_reg <= '0;
                end
                else if (alloc && sum.free_seen)
                begin
                    busy_reg <= busy_reg + 1'b1;
                end
                else if (cmd.erase && sum.hit && busy_reg != '0)
                begin
                    busy_reg <= busy_reg - 1'b1;
                end
                if (wr_en)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (phase_reg == PH_HEAD_SCAN &&
                (h_len == '0 || (!sum.conflict && sum.free_seen)))
            begin
                if (h_len != '0)
                begin
                    busy_reg <= busy_reg + 1'b1;
                end
                fill_reg <= fill_reg - 1'b1;
                head_reg <= (head_reg == PTR_BITS'(WAIT_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
        end
    end

    // Item capture and result fields
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            act_reg    <= s_tdata[1:0];
            lo_reg     <= s_tdata[49:2];
            len_reg    <= s_tdata[81:50];
            tag_reg    <= TAG_BITS'(s_tdata[97:82]);
            queue_reg  <= s_tdata[98];
            acc_reg    <= 1'b0;
            status_reg <= ST_OK;
            iss_reg    <= 1'b0;
            itag_reg   <= '0;
        end
        if (phase_reg == PH_SCAN)
        begin
            if (act_reg == ACT_SUBMIT)
            begin
                if (len_reg == '0 || (!sum.conflict && sum.free_seen))
                begin
                    acc_reg <= 1'b1;
                end
                else if (queue_reg && fill_reg >= FILL_BITS'(WAIT_DEPTH))
                begin
                    status_reg <= ST_WAIT_FULL;
                end
                else if (!sum.conflict)
                begin
                    status_reg <= ST_TABLE_FULL;
                end
            end
            else if (act_reg == ACT_COMPLETE && len_reg != '0 && !sum.hit)
            begin
                status_reg <= ST_ERASE_MISS;
            end
        end
        if (phase_reg == PH_HEAD_SCAN &&
            (h_len == '0 || (!sum.conflict && sum.free_seen)))
        begin
            iss_reg  <= 1'b1;
            itag_reg <= h_tag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, 6'(fill_reg), 7'(busy_reg), status_reg,
                       16'(itag_reg), iss_reg, acc_reg};

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg <= CNT_BITS'(TABLE_ENTRIES))
        else $error("in-flight count above table size");
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_BITS'(WAIT_DEPTH))
        else $error("pending count above FIFO depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> phase_reg == PH_IDLE)
        else $error("result held while item in work");
    assert property (@(posedge clk) disable iff (!rst_n)
        iss_reg && out_valid_reg |-> act_reg == ACT_COMPLETE)
        else $error("release outside completion");
endmodule
`default_nettype wire

@@ tb/tb_inflight_range_conflict_tracker_core.sv @@
`default_nettype none
module tb_inflight_range_conflict_tracker_core;
    import irct_pkg::*;

    localparam int NUM_ENTRIES = 64;
    localparam int NUM_WAIT    = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_MAX    = 2048;

    // First member sits in the top bits, so action lands at bit 0
    typedef struct packed {
        logic        queue;
        logic [15:0] tag;
        logic [31:0] length;
        logic [47:0] offset;
        logic [1:0]  action;
    } io_item_t;

    typedef struct packed {
        logic [5:0]  pending_count;
        logic [6:0]  inflight_count;
        logic [1:0]  status;
        logic [15:0] issued_tag;
        logic        issued_valid;
        logic        accepted;
    } io_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // action, offset, length, request_tag, queue_if_blocked, zero fill
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // accepted, issued_valid, issued_tag, status, inflight_count, pending_count
    logic [39:0]  m_tdata;

    inflight_range_conflict_tracker_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Hazard table and pending FIFO mirror
    logic [47:0] tbl_start [NUM_ENTRIES];
    logic [48:0] tbl_end   [NUM_ENTRIES];
    logic        tbl_valid [NUM_ENTRIES];
    io_item_t    park_fifo [NUM_WAIT];
    int          park_head;
    int          park_fill;
    int          busy;

    // Items to send and results to expect, each with a write and a read index
    io_item_t    item_q [ITEM_MAX];
    int          item_wr;
    int          item_rd;
    io_result_t  exp_q [ITEM_MAX];
    int          exp_wr;
    int          exp_rd;
    int          errors;
    int          cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        s_tready_seen;

    function automatic bit range_is_clear(logic [47:0] lo, logic [31:0] len);
        logic [48:0] hi;
        hi = {1'b0, lo} + {17'd0, len};
        if (len == 0)
            return 1'b1;
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (tbl_valid[i] && {1'b0, tbl_start[i]} < hi && tbl_end[i] > {1'b0, lo})
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic int free_entry();
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (!tbl_valid[i])
                return i;
        return -1;
    endfunction

    function automatic void enter_range(int slot, logic [47:0] lo, logic [31:0] len);
        tbl_start[slot] = lo;
        tbl_end[slot]   = {1'b0, lo} + {17'd0, len};
        tbl_valid[slot] = 1'b1;
        busy++;
    endfunction

    // Compute the result of one item and advance the mirror
    function automatic io_result_t track_item(io_item_t it);
        io_result_t r;
        bit clr;
        bit hit;
        int slot;
        io_item_t hd;
        r = '0;
        case (action_t'(it.action))
            ACT_SUBMIT:
            begin
                if (it.length == 0)
                begin
                    r.accepted = 1'b1;
                end
                else
                begin
                    clr  = range_is_clear(it.offset, it.length);
                    slot = free_entry();
                    if (clr && slot >= 0)
                    begin
                        enter_range(slot, it.offset, it.length);
                        r.accepted = 1'b1;
                    end
                    else
                    begin
                        if (clr)
                            r.status = ST_TABLE_FULL;
                        if (it.queue)
                        begin
                            if (park_fill < NUM_WAIT)
                            begin
                                park_fifo[(park_head + park_fill) % NUM_WAIT] = it;
                                park_fill++;
                            end
                            else
                            begin
                                r.status = ST_WAIT_FULL;
                            end
                        end
                    end
                end
            end
            ACT_COMPLETE:
            begin
                if (it.length != 0)
                begin
                    hit = 1'b0;
                    for (int i = 0; i < NUM_ENTRIES; i++)
                    begin
                        if (!hit && tbl_valid[i] && tbl_start[i] == it.offset)
                        begin
                            tbl_valid[i] = 1'b0;
                            if (busy > 0)
                                busy--;
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                        r.status = ST_ERASE_MISS;
                end
                if (park_fill > 0)
                begin
                    hd  = park_fifo[park_head];
                    clr = 1'b0;
                    if (hd.length == 0)
                    begin
                        clr = 1'b1;
                    end
                    else if (range_is_clear(hd.offset, hd.length))
                    begin
                        slot = free_entry();
                        if (slot >= 0)
                        begin
                            enter_range(slot, hd.offset, hd.length);
                            clr = 1'b1;
                        end
                    end
                    if (clr)
                    begin
                        r.issued_valid = 1'b1;
                        r.issued_tag   = hd.tag;
                        park_head = (park_head + 1) % NUM_WAIT;
                        park_fill--;
                    end
                end
            end
            ACT_CLEAR:
            begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                    tbl_valid[i] = 1'b0;
                park_head = 0;
                park_fill = 0;
                busy      = 0;
            end
            default: ;
        endcase
        r.inflight_count = busy[6:0];
        r.pending_count  = park_fill[5:0];
        return r;
    endfunction

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Handshake flag seen at the last rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tready_seen <= 1'b0;
        else
            s_tready_seen <= s_tvalid && s_tready;
    end

    // Driver: present items at the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready_seen)
        begin
            if (item_rd < item_wr && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {5'd0, item_q[item_rd]};
                item_rd++;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Predict on acceptance
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            exp_q[exp_wr] = track_item(io_item_t'(s_tdata[98:0]));
            exp_wr++;
        end
    end

    // Receiver stall
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        io_result_t got;
        io_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = io_result_t'(m_tdata[32:0]);
            if (exp_rd >= exp_wr)
            begin
                $error("unexpected result %h", m_tdata);
                errors++;
            end
            else
            begin
                exp_r = exp_q[exp_rd];
                exp_rd++;
                if (got.accepted !== exp_r.accepted)
                begin
                    $error("accepted exp %0d got %0d", exp_r.accepted, got.accepted);
                    errors++;
                end
                if (got.issued_valid !== exp_r.issued_valid)
                begin
                    $error("issued_valid exp %0d got %0d", exp_r.issued_valid,
                           got.issued_valid);
                    errors++;
                end
                if (got.issued_tag !== exp_r.issued_tag)
                begin
                    $error("issued_tag exp %0h got %0h", exp_r.issued_tag, got.issued_tag);
                    errors++;
                end
                if (got.status !== exp_r.status)
                begin
                    $error("status exp %0d got %0d", exp_r.status, got.status);
                    errors++;
                end
                if (got.inflight_count !== exp_r.inflight_count)
                begin
                    $error("inflight_count exp %0d got %0d", exp_r.inflight_count,
                           got.inflight_count);
                    errors++;
                end
                if (got.pending_count !== exp_r.pending_count)
                begin
                    $error("pending_count exp %0d got %0d", exp_r.pending_count,
                           got.pending_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic io_item_t make_item(logic [1:0] act, logic [47:0] off,
                                           logic [31:0] len, logic [15:0] tg,
                                           logic q);
        io_item_t it;
        it.action = act;
        it.offset = off;
        it.length = len;
        it.tag    = tg;
        it.queue  = q;
        return it;
    endfunction

    // Append one item to the send list
    task automatic add_item(io_item_t it);
        item_q[item_wr] = it;
        item_wr++;
    endtask

    // Random item biased to a small address window so ranges collide
    function automatic io_item_t random_item();
        logic [47:0] off;
        logic [31:0] len;
        logic [15:0] tg;
        logic        q;
        int sel;
        sel = $urandom_range(99);
        off = 48'({$urandom, $urandom});
        len = $urandom;
        tg  = 16'($urandom);
        q   = 1'($urandom_range(1));
        if (sel < 85)
        begin
            off = 48'($urandom_range(63) * 64);
            len = ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(1, 200);
        end
        sel = $urandom_range(99);
        if (sel < 50)
            return make_item(ACT_SUBMIT, off, len, tg, q);
        if (sel < 95)
            return make_item(ACT_COMPLETE, off, len, tg, q);
        if (sel < 97)
            return make_item(ACT_CLEAR, off, len, tg, q);
        return make_item(ACT_NONE, off, len, tg, q);
    endfunction

    task automatic run_phase(int count);
        for (int i = 0; i < count; i++)
            add_item(random_item());
        while (exp_rd < item_wr)
            @(posedge clk);
    endtask

    initial
    begin
        errors        = 0;
        cycles        = 0;
        item_wr       = 0;
        item_rd       = 0;
        exp_wr        = 0;
        exp_rd        = 0;
        send_idle_pct = 12;
        recv_idle_pct = 72;
        park_head     = 0;
        park_fill     = 0;
        busy          = 0;
        for (int i = 0; i < NUM_ENTRIES; i++)
            tbl_valid[i] = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, every action, special cases
        add_item(make_item(ACT_SUBMIT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
        add_item(make_item(ACT_SUBMIT, 48'hFFFF_FFFF_FFFF, 32'd1, 16'h0001, 1'b1));
        add_item(make_item(ACT_SUBMIT, 48'd0, 32'd0, 16'h0000, 1'b0));
        add_item(make_item(ACT_SUBMIT, 48'd100, 32'd0, 16'h00AA, 1'b1));
        add_item(make_item(ACT_SUBMIT, 48'd0, 32'd10, 16'h1234, 1'b0));
        add_item(make_item(ACT_SUBMIT, 48'd5, 32'd10, 16'h5555, 1'b0));
        add_item(make_item(ACT_SUBMIT, 48'd10, 32'd10, 16'hAAAA, 1'b0));
        add_item(make_item(ACT_SUBMIT, 48'd9, 32'd5, 16'h0BCD, 1'b1));
        add_item(make_item(ACT_COMPLETE, 48'd77, 32'd4, 16'h0, 1'b0));
        add_item(make_item(ACT_COMPLETE, 48'd0, 32'd0, 16'h0, 1'b0));
        add_item(make_item(ACT_COMPLETE, 48'd10, 32'd1, 16'h0, 1'b0));
        add_item(make_item(ACT_NONE, 48'd0, 32'd5, 16'hFFFF, 1'b1));
        add_item(make_item(ACT_COMPLETE, 48'hFFFF_FFFF_FFFF, 32'd1, 16'h0, 1'b0));
        add_item(make_item(ACT_CLEAR, 48'd0, 32'd0, 16'h0, 1'b0));
        // Fill the table, then overflow it and the pending FIFO
        for (int i = 0; i < 64; i++)
            add_item(make_item(ACT_SUBMIT, 48'(i * 16), 32'd8, 16'(i), 1'b0));
        for (int i = 0; i < 34; i++)
            add_item(make_item(ACT_SUBMIT, 48'(32'h10000 + i * 16), 32'd8,
                               16'(16'h100 + i), 1'b1));
        for (int i = 0; i < 40; i++)
            add_item(make_item(ACT_COMPLETE, 48'(i * 16), 32'd8, 16'h0, 1'b0));
        add_item(make_item(ACT_CLEAR, 48'd0, 32'd0, 16'h0, 1'b0));
        while (exp_rd < item_wr)
            @(posedge clk);

        run_phase(400);
        send_idle_pct = 72;
        recv_idle_pct = 12;
        run_phase(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(400);

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
